// ===== rtl/lidar_point_spherical_binner_assert.svh =====
// assertion macros for the spherical binner
`ifndef LIDAR_POINT_SPHERICAL_BINNER_ASSERT_SVH
`define LIDAR_POINT_SPHERICAL_BINNER_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define LPSB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpsb assertion failed");
// clocked check that also holds during reset
`define LPSB_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lpsb reset assertion failed");
`else
`define LPSB_ASSERT(name, prop)
`define LPSB_ASSERT_RST(name, prop)
`endif
`endif

// ===== rtl/lpsb_pkg.sv =====
// shared types and constants of the spherical binner
package lpsb_pkg;

  // cordic datapath widths
  localparam int unsigned CW      = 57;
  localparam int unsigned AW      = 27;
  localparam int unsigned TAB_LEN = 24;

  // atan(2^-i) in 1/65536 degree
  localparam logic signed [AW-1:0] ATAN_TAB [TAB_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117304,
    27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
    27'sd917, 27'sd458, 27'sd229, 27'sd115, 27'sd57, 27'sd29,
    27'sd14, 27'sd7, 27'sd4, 27'sd2, 27'sd1, 27'sd0
  };

  localparam logic signed [AW-1:0] HALF_TURN = 27'sd11796480;
  localparam logic signed [AW-1:0] FULL_TURN = 27'sd23592960;
  localparam logic signed [AW-1:0] ROUND_ADD = 27'sd512;
  localparam logic signed [AW-1:0] ZEN_MAX_A = 27'sd5760;
  localparam logic signed [AW-1:0] AZ_FULL_A = 27'sd23040;

  // output field widths
  localparam int unsigned RANGE_W = 24;
  localparam int unsigned ZEN_W   = 13;
  localparam int unsigned AZ_W    = 15;
  localparam int unsigned CAP_W   = 20;
  localparam int unsigned BIN_W   = 9;
  localparam int unsigned SEC_W   = 3;
  localparam int unsigned DIV_W   = 13;

  localparam logic [ZEN_W-1:0] ZEN_MAX      = 13'd5760;
  localparam int unsigned      HALF_SECTOR  = 1440;
  localparam int unsigned      SECTOR_W     = 2880;
  localparam logic [DIV_W-1:0] BIN_MAX      = 13'd511;

  // configuration register indexes and reset values
  localparam int unsigned      CFG_IDX_W      = 2;
  localparam logic [1:0]       REG_ZEN_START  = 2'd0;
  localparam logic [1:0]       REG_ZEN_END    = 2'd1;
  localparam logic [1:0]       REG_ZEN_STEP   = 2'd2;
  localparam logic [ZEN_W-1:0] RST_ZEN_START  = 13'd1280;
  localparam logic [ZEN_W-1:0] RST_ZEN_END    = 13'd5760;
  localparam logic [ZEN_W-1:0] RST_ZEN_STEP   = 13'd320;

  // one vector being rotated
  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [AW-1:0] acc;
  } cordic_lane_t;

  // fields riding along the divider cells
  typedef struct packed {
    logic               kept;
    logic               zgt;
    logic [RANGE_W-1:0] range;
    logic [ZEN_W-1:0]   zen;
    logic [AZ_W-1:0]    az;
    logic [CAP_W-1:0]   cap;
  } dv_side_t;

endpackage

// ===== rtl/lidar_point_spherical_binner.sv =====
// lidar point to spherical coordinates with zenith bin and azimuth sector
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: x_mm, y_mm, z_mm
//  m_axis    out  m_axis_tvalid/tready      tdata: range..sector, tuser: flags
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
//  one point per clock while the output is not stalled; the pipe is made of
//  the square root cells (one result bit each), the rotation cells and the
//  13 divider cells for the zenith bin
//  the whole pipe holds while the output transfer is stalled
//  reset clears valid flags and loads the register defaults; cfg is always ready
`include "lidar_point_spherical_binner_assert.svh"
module lidar_point_spherical_binner #(
  parameter int unsigned COORD_BITS    = 24,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // x_mm, y_mm, z_mm from bit 0 up
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // range_mm, zenith_angle, azimuth_angle, capture_dist, zenith_bin,
  // azimuth_sector from bit 0 up
  output logic [87:0]                            m_axis_tdata,
  // kept, zenith_bin_valid from bit 0 up
  output logic [1:0]                             m_axis_tuser,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lpsb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lpsb_pkg::ZEN_W-1:0]             cfg_data_i
);
  import lpsb_pkg::*;

  localparam int unsigned CB        = COORD_BITS;
  localparam int unsigned NR        = CB + 5;
  localparam int unsigned OPW       = 2 * NR;
  localparam int unsigned RW        = CB + 1;
  localparam int unsigned CSH       = 54 - CB;
  localparam int unsigned NCS       = CORDIC_STAGES;
  localparam int unsigned NV        = 3 + NR + NCS + 2 + DIV_W + 1;
  localparam int unsigned CAP_SHIFT = RW + 7;
  localparam longint unsigned CAP_MUL_L = ((64'd1 << (RW + 10)) + 64'd124) / 64'd125;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 axis0;
  } sq_side_t;

  typedef struct packed {
    logic          kept;
    logic          axis0;
    logic          neg;
    logic [RW-1:0] range;
  } cs_side_t;

  logic                adv;
  logic [NV-1:0]       vld_q;
  logic [ZEN_W-1:0]    zen_start_q, zen_end_q, zen_step_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zen_start_q <= RST_ZEN_START;
      zen_end_q   <= RST_ZEN_END;
      zen_step_q  <= RST_ZEN_STEP;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ZEN_START: zen_start_q <= cfg_data_i;
        REG_ZEN_END:   zen_end_q   <= cfg_data_i;
        REG_ZEN_STEP:  zen_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipe advances unless the output holds a stalled transfer
  assign adv           = !vld_q[NV-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
    end
  end

  // input register
  logic signed [CB-1:0] x0_q, y0_q, z0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= s_axis_tdata[CB-1:0];
      y0_q <= s_axis_tdata[2*CB-1:CB];
      z0_q <= s_axis_tdata[3*CB-1:2*CB];
    end
  end

  // squares
  logic signed [2*CB-1:0] xsq_s, ysq_s, zsq_s;
  logic [2*CB-1:0]        xsq_q, ysq_q, zsq_q;
  sq_side_t               s1_q, s2_q;
  assign xsq_s = x0_q * x0_q;
  assign ysq_s = y0_q * y0_q;
  assign zsq_s = z0_q * z0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xsq_q <= xsq_s;
      ysq_q <= ysq_s;
      zsq_q <= zsq_s;
      s1_q  <= '{x: x0_q, y: y0_q, z: z0_q, axis0: (x0_q == '0) && (y0_q == '0)};
    end
  end

  // horizontal and full squared distance
  logic [2*CB:0]   hsq_q;
  logic [2*CB+1:0] rsq_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hsq_q <= (2*CB+1)'(xsq_q) + (2*CB+1)'(ysq_q);
      rsq_q <= (2*CB+2)'(xsq_q) + (2*CB+2)'(ysq_q) + (2*CB+2)'(zsq_q);
      s2_q  <= s1_q;
    end
  end

  // square root cells, rho with four fraction bits and range
  logic [OPW-1:0] op_rho [NR+1];
  logic [OPW-1:0] op_rng [NR+1];
  logic [NR-1:0]  rt_rho [NR+1];
  logic [NR-1:0]  rt_rng [NR+1];
  logic [NR+1:0]  rm_rho [NR+1];
  logic [NR+1:0]  rm_rng [NR+1];
  sq_side_t       sqs_q  [NR];

  assign op_rho[0] = OPW'({hsq_q, 8'b0});
  assign op_rng[0] = OPW'(rsq_q);
  assign rt_rho[0] = '0;
  assign rt_rng[0] = '0;
  assign rm_rho[0] = '0;
  assign rm_rng[0] = '0;

  for (genvar i = 0; i < NR; i++) begin : g_sqrt
    lpsb_sqrt_cell #(.NR(NR)) u_rho (
      .clk_i, .en_i(adv),
      .op_i(op_rho[i]), .root_i(rt_rho[i]), .rem_i(rm_rho[i]),
      .op_o(op_rho[i+1]), .root_o(rt_rho[i+1]), .rem_o(rm_rho[i+1])
    );
    lpsb_sqrt_cell #(.NR(NR)) u_rng (
      .clk_i, .en_i(adv),
      .op_i(op_rng[i]), .root_i(rt_rng[i]), .rem_i(rm_rng[i]),
      .op_o(op_rng[i+1]), .root_o(rt_rng[i+1]), .rem_o(rm_rng[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqs_q[i] <= (i == 0) ? s2_q : sqs_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // rotation inputs: zenith vector (z, rho), azimuth vector (y, x) folded right
  sq_side_t             sq_last;
  logic                 neg_y;
  logic signed [CW-1:0] xw, yw;
  cordic_lane_t         zl [NCS+1];
  cordic_lane_t         al [NCS+1];
  cs_side_t             cs_q [NCS];

  always_comb begin
    sq_last = sqs_q[NR-1];
    neg_y   = sq_last.y < 0;
    xw      = CW'(sq_last.x);
    yw      = CW'(sq_last.y);
  end

  assign zl[0].a   = CW'(sq_last.z) <<< CSH;
  assign zl[0].b   = CW'({1'b0, rt_rho[NR]}) <<< (CSH - 4);
  assign zl[0].acc = '0;
  assign al[0].a   = (neg_y ? -yw : yw) <<< CSH;
  assign al[0].b   = (neg_y ? -xw : xw) <<< CSH;
  assign al[0].acc = '0;

  for (genvar i = 0; i < NCS; i++) begin : g_cordic
    lpsb_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i, .en_i(adv),
      .zen_i(zl[i]), .az_i(al[i]), .zen_o(zl[i+1]), .az_o(al[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (i == 0) begin
          cs_q[i] <= '{kept: sq_last.z > 0, axis0: sq_last.axis0, neg: neg_y,
                       range: rt_rng[NR][RW-1:0]};
        end else begin
          cs_q[i] <= cs_q[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // zenith rounding and azimuth wrap
  logic signed [AW-1:0] accz, zt, ang0, ang1;
  logic [ZEN_W-1:0]     zen_d, zen1_q;
  logic signed [AW-1:0] ang1_q;
  cs_side_t             cs1_q;
  always_comb begin
    accz = zl[NCS].acc;
    zt   = (accz + ROUND_ADD) >>> 10;
    if (accz < 0) begin
      zen_d = '0;
    end else if (zt > ZEN_MAX_A) begin
      zen_d = ZEN_MAX;
    end else begin
      zen_d = zt[ZEN_W-1:0];
    end
    ang0 = al[NCS].acc + (cs_q[NCS-1].neg ? HALF_TURN : '0);
    if (ang0 < 0) begin
      ang1 = ang0 + FULL_TURN;
    end else if (ang0 >= FULL_TURN) begin
      ang1 = ang0 - FULL_TURN;
    end else begin
      ang1 = ang0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zen1_q <= zen_d;
      ang1_q <= ang1;
      cs1_q  <= cs_q[NCS-1];
    end
  end

  // azimuth rounding, capture distance product, divider operands
  logic signed [AW-1:0] azr;
  logic [AZ_W-1:0]      az_d, az2_q;
  logic [2*RW+3:0]      cap_prod_q;
  logic [ZEN_W-1:0]     zen2_q, num2_q;
  logic                 zgt2_q, kept2_q;
  logic [RW-1:0]        range2_q;
  always_comb begin
    azr = (ang1_q + ROUND_ADD) >>> 10;
    if (cs1_q.axis0) begin
      az_d = '0;
    end else if (azr >= AZ_FULL_A) begin
      az_d = AZ_W'(azr - AZ_FULL_A);
    end else begin
      az_d = azr[AZ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      az2_q      <= az_d;
      cap_prod_q <= (2*RW+4)'(cs1_q.range) * (2*RW+4)'(CAP_MUL_L[RW+3:0]);
      zen2_q     <= zen1_q;
      num2_q     <= zen1_q - zen_start_q - 13'd1;
      zgt2_q     <= (zen1_q > zen_start_q) && (zen_step_q != '0);
      kept2_q    <= cs1_q.kept;
      range2_q   <= cs1_q.range;
    end
  end

  // divider cells for the zenith bin
  logic [DIV_W-1:0] dv_num [DIV_W+1];
  logic [DIV_W-1:0] dv_quo [DIV_W+1];
  logic [DIV_W-1:0] dv_rem [DIV_W+1];
  dv_side_t         dvs_q  [DIV_W];
  dv_side_t         dv_in;

  assign dv_num[0] = num2_q;
  assign dv_quo[0] = '0;
  assign dv_rem[0] = '0;
  assign dv_in = '{kept: kept2_q, zgt: zgt2_q, range: RANGE_W'(range2_q), zen: zen2_q,
                   az: az2_q, cap: CAP_W'(cap_prod_q >> CAP_SHIFT)};

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    lpsb_div_cell u_cell (
      .clk_i, .en_i(adv), .divisor_i(zen_step_q),
      .num_i(dv_num[i]), .quo_i(dv_quo[i]), .rem_i(dv_rem[i]),
      .num_o(dv_num[i+1]), .quo_o(dv_quo[i+1]), .rem_o(dv_rem[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dvs_q[i] <= (i == 0) ? dv_in : dvs_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // bin limits, sector count and ground masking
  dv_side_t         fin;
  logic [DIV_W-1:0] quo;
  logic [DIV_W:0]   lower;
  logic             bvalid;
  logic [BIN_W-1:0] bin;
  logic [SEC_W-1:0] sector;
  logic [87:0]      data_d, data_q;
  logic [1:0]       user_d, user_q;
  always_comb begin
    fin    = dvs_q[DIV_W-1];
    quo    = dv_quo[DIV_W];
    lower  = {1'b0, fin.zen} - 14'd1 - {1'b0, dv_rem[DIV_W]};
    bvalid = fin.zgt && (lower <= {1'b0, zen_end_q}) && (quo <= BIN_MAX);
    if (!fin.zgt) begin
      bin = '0;
    end else if (quo > BIN_MAX) begin
      bin = BIN_MAX[BIN_W-1:0];
    end else begin
      bin = quo[BIN_W-1:0];
    end
    sector = '0;
    for (int j = 0; j < 8; j++) begin
      sector = sector + SEC_W'(fin.az > AZ_W'(HALF_SECTOR + j * SECTOR_W));
    end
    if (fin.kept) begin
      data_d = {4'b0, sector, bin, fin.cap, fin.az, fin.zen, fin.range};
      user_d = {bvalid, 1'b1};
    end else begin
      data_d = '0;
      user_d = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tdata = data_q;
  assign m_axis_tuser = user_q;

  // checks
  `LPSB_ASSERT(ground_all_zero_a,
               m_axis_tvalid && !user_q[0] |-> data_q == '0 && !user_q[1])
  `LPSB_ASSERT(bin_above_start_a,
               m_axis_tvalid && user_q[1] |-> data_q[36:24] > zen_start_q)
  `LPSB_ASSERT(angle_range_a,
               m_axis_tvalid |-> data_q[51:37] < 15'd23040 && data_q[36:24] <= ZEN_MAX)
  `LPSB_ASSERT_RST(no_output_in_reset_a, !rst_ni |-> !m_axis_tvalid)

endmodule

// ===== rtl/lpsb_sqrt_cell.sv =====
// one digit cell of the pipelined square root
module lpsb_sqrt_cell #(
  parameter int unsigned NR = 29
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*NR-1:0] op_i,
  input  logic [NR-1:0]   root_i,
  input  logic [NR+1:0]   rem_i,
  output logic [2*NR-1:0] op_o,
  output logic [NR-1:0]   root_o,
  output logic [NR+1:0]   rem_o
);
  logic [NR+3:0]   rem_sh, trial;
  logic            take;
  logic [2*NR-1:0] op_d, op_q;
  logic [NR-1:0]   root_d, root_q;
  logic [NR+1:0]   rem_d, rem_q;

  // trial subtract of the next two operand bits
  always_comb begin
    rem_sh = {rem_i, op_i[2*NR-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    take   = (rem_sh >= trial);
    op_d   = {op_i[2*NR-3:0], 2'b00};
    root_d = {root_i[NR-2:0], take};
    rem_d  = take ? (NR+2)'(rem_sh - trial) : rem_sh[NR+1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_d;
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign op_o   = op_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/lpsb_cordic_cell.sv =====
// one rotation cell, zenith and azimuth lanes side by side
module lpsb_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  lpsb_pkg::cordic_lane_t zen_i,
  input  lpsb_pkg::cordic_lane_t az_i,
  output lpsb_pkg::cordic_lane_t zen_o,
  output lpsb_pkg::cordic_lane_t az_o
);
  import lpsb_pkg::*;

  cordic_lane_t zen_d, zen_q, az_d, az_q;

  // rotate toward the positive a axis
  function automatic cordic_lane_t rotate(input cordic_lane_t l);
    cordic_lane_t r;
    if (l.b > 0) begin
      r.a   = l.a + (l.b >>> STAGE);
      r.b   = l.b - (l.a >>> STAGE);
      r.acc = l.acc + ATAN_TAB[STAGE];
    end else begin
      r.a   = l.a - (l.b >>> STAGE);
      r.b   = l.b + (l.a >>> STAGE);
      r.acc = l.acc - ATAN_TAB[STAGE];
    end
    return r;
  endfunction

  always_comb begin
    zen_d = rotate(zen_i);
    az_d  = rotate(az_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zen_q <= zen_d;
      az_q  <= az_d;
    end
  end

  assign zen_o = zen_q;
  assign az_o  = az_q;
endmodule

// ===== rtl/lpsb_div_cell.sv =====
// one quotient bit of the pipelined bin divider
module lpsb_div_cell (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [lpsb_pkg::DIV_W-1:0] divisor_i,
  input  logic [lpsb_pkg::DIV_W-1:0] num_i,
  input  logic [lpsb_pkg::DIV_W-1:0] quo_i,
  input  logic [lpsb_pkg::DIV_W-1:0] rem_i,
  output logic [lpsb_pkg::DIV_W-1:0] num_o,
  output logic [lpsb_pkg::DIV_W-1:0] quo_o,
  output logic [lpsb_pkg::DIV_W-1:0] rem_o
);
  import lpsb_pkg::*;

  logic [DIV_W:0]   rem_sh;
  logic             take;
  logic [DIV_W-1:0] num_d, num_q, quo_d, quo_q, rem_d, rem_q;

  // shift in the next numerator bit and try the divisor
  always_comb begin
    rem_sh = {rem_i, num_i[DIV_W-1]};
    take   = (rem_sh >= {1'b0, divisor_i});
    num_d  = {num_i[DIV_W-2:0], 1'b0};
    quo_d  = {quo_i[DIV_W-2:0], take};
    rem_d  = take ? DIV_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign num_o = num_q;
  assign quo_o = quo_q;
  assign rem_o = rem_q;
endmodule
